// File: src/dcc_pkg.sv
// Package: types, constants and sequence tables for downline carriage control.
`timescale 1ns / 1ps

package dcc_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam logic [7:0] UNIT_SEP = 8'h1F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_J     = 8'h4A;

    localparam logic [7:0] FE_SINGLE = 8'h20;
    localparam logic [7:0] FE_DOUBLE = 8'h30;
    localparam logic [7:0] FE_TRIPLE = 8'h2D;
    localparam logic [7:0] FE_NOADV  = 8'h2B;
    localparam logic [7:0] FE_HOME   = 8'h2A;
    localparam logic [7:0] FE_PAGE   = 8'h31;
    localparam logic [7:0] FE_T_CRLF = 8'h2E;
    localparam logic [7:0] FE_T_CR   = 8'h2F;

    typedef enum logic [1:0] {
        OP_HEADER = 2'd0,
        OP_DATA   = 2'd1,
        OP_LINE   = 2'd2,
        OP_UNUSED = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        LD_NONE, LD_CR, LD_SINGLE, LD_DOUBLE, LD_TRIPLE, LD_FF, LD_HOME, LD_CLEAR_HOME
    } lead_t;

    typedef enum logic [1:0] {
        TR_NONE, TR_CRLF, TR_CR
    } trail_t;

    typedef struct packed {
        lead_t      lead;
        trail_t     trail;
        logic       has_text;
        logic [7:0] text;
    } cmd_t;

    function automatic logic [3:0] lead_len(lead_t k);
        case (k)
            LD_CR:         lead_len = 4'd1;
            LD_SINGLE:     lead_len = 4'd2;
            LD_DOUBLE:     lead_len = 4'd3;
            LD_TRIPLE:     lead_len = 4'd4;
            LD_FF:         lead_len = 4'd1;
            LD_HOME:       lead_len = 4'd5;
            LD_CLEAR_HOME: lead_len = 4'd8;
            default:       lead_len = 4'd0;
        endcase
    endfunction

    function automatic logic [7:0] lead_byte(lead_t k, logic [2:0] i);
        case (k)
            LD_FF:   lead_byte = CH_FF;
            LD_CR:   lead_byte = CH_CR;
            LD_HOME, LD_CLEAR_HOME: begin
                case (i)
                    3'd0:    lead_byte = CH_CR;
                    3'd1:    lead_byte = CH_LF;
                    3'd2:    lead_byte = CH_ESC;
                    3'd3:    lead_byte = CH_LBRK;
                    3'd4:    lead_byte = CH_H;
                    3'd5:    lead_byte = CH_ESC;
                    3'd6:    lead_byte = CH_LBRK;
                    default: lead_byte = CH_J;
                endcase
            end
            default: lead_byte = (i == 3'd0) ? CH_CR : CH_LF;
        endcase
    endfunction

    function automatic logic [3:0] trail_len(trail_t k);
        case (k)
            TR_CRLF: trail_len = 4'd2;
            TR_CR:   trail_len = 4'd1;
            default: trail_len = 4'd0;
        endcase
    endfunction

    function automatic logic [7:0] trail_byte(logic [2:0] i);
        trail_byte = (i == 3'd0) ? CH_CR : CH_LF;
    endfunction

endpackage

// File: src/dcc_front.sv
// Front end: accepts requests, tracks line/mode state, builds output commands.
`timescale 1ns / 1ps

module dcc_front
    import dcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        ansi_terminal,
    input  logic        in_valid,
    input  logic [1:0]  in_opcode,
    input  logic [7:0]  in_byte,
    input  logic        in_transparent,
    input  logic        in_no_effector,
    input  logic        in_no_cursor_pos,
    output logic        in_ready,
    input  logic        q_ready,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic       transparent_reg, transparent_next;
    logic       no_eff_reg, no_eff_next;
    logic       no_cpos_reg, no_cpos_next;
    logic       line_start_reg, line_start_next;
    logic [7:0] saved_eff_reg, saved_eff_next;
    logic       prev_in_reg, prev_in_next;

    logic       accept;
    logic [7:0] eff;
    cmd_t       cmd;
    logic [3:0] total;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    assign eff      = no_eff_reg ? CH_SPACE : in_byte;

    always_comb begin
        transparent_next = transparent_reg;
        no_eff_next      = no_eff_reg;
        no_cpos_next     = no_cpos_reg;
        line_start_next  = line_start_reg;
        saved_eff_next   = saved_eff_reg;
        prev_in_next     = prev_in_reg;
        cmd.lead     = LD_NONE;
        cmd.trail    = TR_NONE;
        cmd.has_text = 1'b0;
        cmd.text     = in_byte;
        case (opcode_t'(in_opcode))
            OP_HEADER: begin
                transparent_next = in_transparent;
                no_eff_next      = in_no_effector;
                no_cpos_next     = in_no_cursor_pos;
                line_start_next  = 1'b1;
            end
            OP_LINE: begin
                prev_in_next = 1'b1;
            end
            OP_DATA: begin
                if (transparent_reg) begin
                    cmd.has_text = 1'b1;
                end else begin
                    if (line_start_reg) begin
                        line_start_next = 1'b0;
                        saved_eff_next  = eff;
                        prev_in_next    = 1'b0;
                        case (eff)
                            FE_SINGLE: cmd.lead = prev_in_reg ? LD_CR : LD_SINGLE;
                            FE_DOUBLE: cmd.lead = prev_in_reg ? LD_SINGLE : LD_DOUBLE;
                            FE_TRIPLE: cmd.lead = prev_in_reg ? LD_DOUBLE : LD_TRIPLE;
                            FE_NOADV:  cmd.lead = LD_CR;
                            FE_HOME:   cmd.lead = ansi_terminal ? LD_HOME : LD_FF;
                            FE_PAGE:   cmd.lead = ansi_terminal ? LD_CLEAR_HOME : LD_FF;
                            default:   cmd.lead = LD_NONE;
                        endcase
                    end
                    if (!line_start_reg || no_eff_reg) begin
                        if (in_byte == UNIT_SEP) begin
                            line_start_next = 1'b1;
                            if (!no_cpos_reg) begin
                                if (saved_eff_next == FE_T_CRLF) begin
                                    cmd.trail = TR_CRLF;
                                end else if (saved_eff_next == FE_T_CR) begin
                                    cmd.trail = TR_CR;
                                end
                            end
                        end else begin
                            cmd.has_text = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign total  = lead_len(cmd.lead) + trail_len(cmd.trail) + {3'd0, cmd.has_text};
    assign q_push = accept && (total != 4'd0);
    assign q_cmd  = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            transparent_reg <= 1'b0;
            no_eff_reg      <= 1'b0;
            no_cpos_reg     <= 1'b0;
            line_start_reg  <= 1'b1;
            saved_eff_reg   <= CH_SPACE;
            prev_in_reg     <= 1'b0;
        end else if (accept) begin
            transparent_reg <= transparent_next;
            no_eff_reg      <= no_eff_next;
            no_cpos_reg     <= no_cpos_next;
            line_start_reg  <= line_start_next;
            saved_eff_reg   <= saved_eff_next;
            prev_in_reg     <= prev_in_next;
        end
    end

endmodule

// File: src/dcc_queue.sv
// Command queue between front and back ends.
`timescale 1ns / 1ps

module dcc_queue
    import dcc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic can_push,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign can_push   = (count_reg != FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && can_push;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/dcc_back.sv
// Back end: expands one command into terminal bytes, one per cycle while out_ready is high.
`timescale 1ns / 1ps

module dcc_back
    import dcc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  cmd_t       head_cmd,
    output logic       pop,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       out_last,
    input  logic       out_ready
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       load;
    logic [3:0] llen, tlen, total, pos;

    assign llen  = lead_len(head_cmd.lead);
    assign tlen  = trail_len(head_cmd.trail);
    assign total = llen + tlen + {3'd0, head_cmd.has_text};
    assign pos   = {1'b0, idx_reg};
    assign load  = head_valid && (!valid_reg || out_ready);

    always_comb begin
        if (pos < llen) begin
            byte_next = lead_byte(head_cmd.lead, idx_reg);
        end else if (pos < llen + tlen) begin
            byte_next = trail_byte(idx_reg - llen[2:0]);
        end else begin
            byte_next = head_cmd.text;
        end
        last_next = (pos == total - 4'd1);
        idx_next  = last_next ? 3'd0 : idx_reg + 3'd1;
    end

    assign pop       = load && last_next;
    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= byte_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg   <= idx_next;
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: src/downline_carriage_control.sv
// Downline carriage control: print-line requests to terminal byte stream.
// When the queue is empty and the back end idle, the first byte of a request passes
// through the queue slot register and then the back-end byte register to m_tdata.
// Throughput: one request accepted per cycle while the queue has room; one output byte
// per cycle while m_tready is high; a request yields 0 to 8 bytes, sent in turn by the back end.
// Reset (aresetn low, synchronous): queue empty, modes cleared, line start set,
// saved effector space, ansi_terminal cleared.
`timescale 1ns / 1ps

module downline_carriage_control
    import dcc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // ansi_terminal
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // data_byte[7:0], hdr_transparent[8],
                                       // hdr_no_effector[9], hdr_no_cursor_pos[10], zero
    input  logic [1:0]  s_tuser,       // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // out_byte[7:0]
    output logic        m_tlast        // last_of_run
);

    logic ansi_reg;
    logic q_push, q_ready, q_pop, q_head_valid;
    cmd_t q_cmd, q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ansi_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            ansi_reg <= cfg_wr_data;
        end
    end

    dcc_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ansi_terminal    (ansi_reg),
        .in_valid         (s_tvalid),
        .in_opcode        (s_tuser),
        .in_byte          (s_tdata[7:0]),
        .in_transparent   (s_tdata[8]),
        .in_no_effector   (s_tdata[9]),
        .in_no_cursor_pos (s_tdata[10]),
        .in_ready         (s_tready),
        .q_ready          (q_ready),
        .q_push           (q_push),
        .q_cmd            (q_cmd)
    );

    dcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .can_push   (q_ready),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head)
    );

    dcc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_cmd   (q_head),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_byte   (m_tdata),
        .out_last   (m_tlast),
        .out_ready  (m_tready)
    );

endmodule

// File: tb/tb.sv
// Self-checking testbench for downline_carriage_control: directed and random print blocks.
`timescale 1ns / 1ps
module tb;
    import dcc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_STALL    = 300;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } term_byte_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = 16'd0;
    logic [1:0]  s_tuser     = 2'd0;
    logic        m_tvalid;
    logic        m_tready    = 1'b1;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    // terminal model state
    logic       ansi_mode        = 1'b0;
    logic       transparent_mode = 1'b0;
    logic       no_effector_mode = 1'b0;
    logic       no_cursor_mode   = 1'b0;
    logic       line_start       = 1'b1;
    logic [7:0] held_effector    = FE_SINGLE;
    logic       after_input      = 1'b0;

    term_byte_t term_q[$];
    logic [7:0] run_bytes[$];
    term_byte_t want;

    int   fails      = 0;
    int   cycles     = 0;
    int   data_items = 0;
    logic quiet      = 1'b0;
    logic stall_req  = 1'b0;
    logic stall_seen = 1'b0;
    int   stall_left = 0;

    downline_carriage_control u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("downline_carriage_control regression: fail");
            $finish;
        end
    end

    function automatic void push_lead(input logic [7:0] fe);
        case (fe)
            FE_SINGLE: begin
                run_bytes.push_back(CH_CR);
                if (!after_input) run_bytes.push_back(CH_LF);
            end
            FE_DOUBLE: begin
                run_bytes.push_back(CH_CR);
                run_bytes.push_back(CH_LF);
                if (!after_input) run_bytes.push_back(CH_LF);
            end
            FE_TRIPLE: begin
                run_bytes.push_back(CH_CR);
                run_bytes.push_back(CH_LF);
                run_bytes.push_back(CH_LF);
                if (!after_input) run_bytes.push_back(CH_LF);
            end
            FE_NOADV: run_bytes.push_back(CH_CR);
            FE_HOME, FE_PAGE: begin
                if (ansi_mode) begin
                    run_bytes.push_back(CH_CR);
                    run_bytes.push_back(CH_LF);
                    run_bytes.push_back(CH_ESC);
                    run_bytes.push_back(CH_LBRK);
                    run_bytes.push_back(CH_H);
                    if (fe == FE_PAGE) begin
                        run_bytes.push_back(CH_ESC);
                        run_bytes.push_back(CH_LBRK);
                        run_bytes.push_back(CH_J);
                    end
                end else begin
                    run_bytes.push_back(CH_FF);
                end
            end
            default: ;
        endcase
        after_input = 1'b0;
    endfunction

    // fl: {no_cursor_pos, no_effector, transparent}
    function automatic void predict_terminal_bytes(input opcode_t op, input logic [7:0] b,
                                                   input logic [2:0] fl);
        logic is_text;
        is_text = 1'b1;
        run_bytes.delete();
        case (op)
            OP_HEADER: begin
                transparent_mode = fl[0];
                no_effector_mode = fl[1];
                no_cursor_mode   = fl[2];
                line_start       = 1'b1;
            end
            OP_LINE: after_input = 1'b1;
            OP_DATA: begin
                if (transparent_mode) begin
                    run_bytes.push_back(b);
                end else begin
                    if (line_start) begin
                        line_start = 1'b0;
                        if (no_effector_mode) begin
                            held_effector = FE_SINGLE;
                            push_lead(FE_SINGLE);
                        end else begin
                            held_effector = b;
                            push_lead(b);
                            is_text = 1'b0;
                        end
                    end
                    if (is_text) begin
                        if (b == UNIT_SEP) begin
                            if (!no_cursor_mode && held_effector == FE_T_CRLF) begin
                                run_bytes.push_back(CH_CR);
                                run_bytes.push_back(CH_LF);
                            end else if (!no_cursor_mode && held_effector == FE_T_CR) begin
                                run_bytes.push_back(CH_CR);
                            end
                            line_start = 1'b1;
                        end else begin
                            run_bytes.push_back(b);
                        end
                    end
                end
            end
            default: ;
        endcase
        foreach (run_bytes[k])
            term_q.push_back(term_byte_t'{value: run_bytes[k],
                                          last: (k == run_bytes.size() - 1)});
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (term_q.size() == 0) begin
                $error("out_byte: expected none, got %h", m_tdata);
                fails++;
            end else begin
                want = term_q.pop_front();
                if (m_tdata !== want.value) begin
                    $error("out_byte: expected %h, got %h", want.value, m_tdata);
                    fails++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_of_run: expected %b, got %b", want.last, m_tlast);
                    fails++;
                end
            end
        end
        if (stall_req != stall_seen) begin
            stall_seen <= stall_req;
            stall_left <= LONG_STALL;
            m_tready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 9);
        end
    end

    task automatic send_item(input opcode_t op, input logic [7:0] b, input logic [2:0] fl);
        if (!quiet && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, fl, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_terminal_bytes(op, b, fl);
        if (op != OP_UNUSED) data_items++;
    endtask

    task automatic send_data(input logic [7:0] b);
        send_item(OP_DATA, b, 3'($urandom_range(7)));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (term_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_ansi(input logic v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ansi_mode = v;
    endtask

    task automatic test_formfeed_lines();
        set_ansi(1'b0);
        send_item(OP_HEADER, 8'h00, 3'b000);
        send_data(FE_PAGE);
        send_data(8'h00);
        send_data(8'hFF);
        send_data(UNIT_SEP);
        send_item(OP_LINE, 8'hA5, 3'b111);
        send_data(FE_TRIPLE);
        send_data(UNIT_SEP);
        send_data(FE_T_CRLF);
        send_data("x");
        send_data(UNIT_SEP);
        send_item(OP_UNUSED, 8'h5A, 3'b101);
        // separator in effector position does not end the line
        send_data(UNIT_SEP);
        send_data("a");
        send_data(UNIT_SEP);
        send_item(OP_HEADER, 8'hFF, 3'b010);
        send_data("h");
        send_data(UNIT_SEP);
        send_item(OP_HEADER, 8'h00, 3'b110);
        send_data(UNIT_SEP);
        send_item(OP_HEADER, 8'h00, 3'b001);
        send_data(UNIT_SEP);
        send_data(CH_CR);
    endtask

    task automatic test_ansi_lines();
        set_ansi(1'b1);
        send_item(OP_HEADER, 8'h00, 3'b000);
        send_data(FE_HOME);
        send_data(UNIT_SEP);
        send_data(FE_PAGE);
        send_data(UNIT_SEP);
        send_item(OP_LINE, 8'h00, 3'b000);
        send_data(FE_SINGLE);
        send_data(UNIT_SEP);
        send_item(OP_LINE, 8'h00, 3'b000);
        send_data(FE_DOUBLE);
        send_data(UNIT_SEP);
        send_data(FE_NOADV);
        send_data(UNIT_SEP);
        send_data(FE_T_CR);
        send_data(UNIT_SEP);
    endtask

    task automatic send_random_block();
        logic [2:0] fl;
        logic [7:0] fe;
        int         lines;
        fl = {($urandom_range(3) == 0), ($urandom_range(3) == 0), ($urandom_range(5) == 0)};
        send_item(OP_HEADER, 8'($urandom_range(255)), fl);
        lines = $urandom_range(1, 4);
        repeat (lines) begin
            if ($urandom_range(5) == 0) send_item(OP_LINE, 8'($urandom_range(255)),
                                                  3'($urandom_range(7)));
            if ($urandom_range(11) == 0) send_item(OP_UNUSED, 8'($urandom_range(255)),
                                                   3'($urandom_range(7)));
            if (!fl[1]) begin
                case ($urandom_range(9))
                    0: fe = FE_SINGLE;
                    1: fe = FE_DOUBLE;
                    2: fe = FE_TRIPLE;
                    3: fe = FE_NOADV;
                    4: fe = FE_HOME;
                    5: fe = FE_PAGE;
                    6: fe = FE_T_CRLF;
                    7: fe = FE_T_CR;
                    8: fe = UNIT_SEP;
                    default: fe = 8'($urandom_range(255));
                endcase
                send_data(fe);
            end
            repeat ($urandom_range(0, 5)) send_data(8'($urandom_range(255)));
            if ($urandom_range(14) != 0) send_data(UNIT_SEP);
        end
    endtask

    task automatic test_random_blocks();
        int goal;
        for (int phase = 0; phase < 4; phase++) begin
            set_ansi(1'(phase % 2));
            quiet <= (phase == 2);
            goal = data_items + 65;
            while (data_items < goal) send_random_block();
        end
        quiet <= 1'b0;
    endtask

    task automatic test_output_stall();
        set_ansi(1'b1);
        send_item(OP_HEADER, 8'h00, 3'b000);
        stall_req <= ~stall_req;
        repeat (12) begin
            send_data(FE_PAGE);
            send_data("z");
            send_data(UNIT_SEP);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_formfeed_lines();
        test_ansi_lines();
        test_random_blocks();
        test_output_stall();
        wait_idle();
        if (fails == 0) begin
            $display("downline_carriage_control regression: pass");
        end else begin
            $display("downline_carriage_control regression: fail");
        end
        $finish;
    end

endmodule
